/* rtl/cfe_pkg.sv */
// types, codes and helpers shared by the central force euler step unit
package cfe_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_H_GO,
    ST_H_WAIT,
    ST_G_CHK,
    ST_G_WAIT,
    ST_U_GO,
    ST_U_WAIT,
    ST_F_MUL,
    ST_F_ACC,
    ST_P_MUL,
    ST_P_ADD,
    ST_V_MUL,
    ST_V_GO,
    ST_V_WAIT,
    ST_K_MUL,
    ST_K_ACC,
    ST_K_HI,
    ST_K_LO,
    ST_K_FIN,
    ST_OUT
  } state_e;

  typedef enum logic {
    UOP_DIV,
    UOP_SQRT
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  localparam logic [1:0] CFG_TIME_STEP = 2'd0;
  localparam logic [1:0] CFG_FORCE     = 2'd1;
  localparam logic [1:0] CFG_MASS      = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [30:0] U31_MAX = 31'h7fff_ffff;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    logic [31:0] n;
    n = ~x + 32'd1;
    return x[31] ? n : x;
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    if (!v[63] && (v[62:31] != 32'd0)) begin
      r = 32'h7fff_ffff;
    end else if (v[63] && (v[62:31] != 32'hffff_ffff)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/cfe_divsqrt.sv */
// shared iterative unit: 64/32 restoring divide, one bit a cycle, or 64-bit integer square root
module cfe_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfe_pkg::unit_req_t req_i,
  input  logic [63:0]       dividend_i,
  input  logic [31:0]       divisor_i,
  output logic [63:0]       result_o,
  output logic              done_o
);

  logic                busy_q;
  logic                done_q;
  logic [5:0]          cnt_q;
  cfe_pkg::unit_op_e   op_q;
  logic [63:0]         quo_q;
  logic [32:0]         rem_q;
  logic [31:0]         dvs_q;
  logic [63:0]         res_q;
  logic [63:0]         bit_q;

  logic [32:0] rem_sh;
  logic        fits;
  logic [63:0] trial;
  logic        take;

  assign rem_sh = {rem_q[31:0], quo_q[63]};
  assign fits   = rem_sh >= {1'b0, dvs_q};
  assign trial  = res_q + bit_q;
  assign take   = quo_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= cfe_pkg::UOP_DIV;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == cfe_pkg::UOP_SQRT) ? 6'd31 : 6'd63;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (op_q == cfe_pkg::UOP_DIV) begin
        if (fits) begin
          rem_q <= rem_sh - {1'b0, dvs_q};
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end else begin
        if (take) begin
          quo_q <= quo_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign result_o = (op_q == cfe_pkg::UOP_SQRT) ? res_q : quo_q;
  assign done_o   = done_q;

endmodule

/* rtl/central_force_euler_step_unit.sv */
// top level: euler step of one particle in an inverse-square central force
//
//  channel   dir  handshake                      word
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser func, tdata initial state
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata position, distance, energies, time, flag
//  cfg       in   cfg_we_i, no wait              cfg_idx_i, cfg_data_i
//
// a load word is taken in idle and leaves the unit ready; a step word uses the shared
// unit once for the square root and 2 + 2*DIMS times to divide before its result; a
// saturated force gain skips one divide and a zero distance skips all force divides
// one word at a time: s_axis_tready is low from a step until its result is taken
// reset clears state, position, velocity and time to zero and loads register defaults
module central_force_euler_step_unit #(
  parameter int DIMS      = 3,
  parameter int FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [223:0]  s_axis_tdata,  // load_pos_x/y/z, load_vel_x/y/z, load_time
  input  logic          s_axis_tuser,  // func
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [223:0]  m_axis_tdata,  // pos_x/y/z, distance, kinetic_energy,
                                       // potential_energy, sim_time, singular, pad
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [30:0]   cfg_data_i
);

  cfe_pkg::state_e state_q, state_d;

  logic [15:0] dt_q;
  logic [30:0] force_q;
  logic [30:0] mass_q;
  logic [30:0] mass;

  logic [31:0] pos_q [3];
  logic [31:0] vel_q [3];
  logic [31:0] time_q;
  logic        fneg_q [3];
  logic [30:0] fmag_q [3];

  logic [1:0]  idx_q;
  logic [63:0] acc_q;
  logic [31:0] r_q;
  logic [63:0] h_q;
  logic [30:0] g_q;
  logic [31:0] u_q;
  logic [63:0] tmp_q;
  logic        hisat_q;
  logic        sing_q;
  logic [31:0] pot_q;
  logic [30:0] ke_q;
  logic [63:0] prod_q;

  logic [31:0] mul_a, mul_b;
  cfe_pkg::unit_req_t req;
  logic [63:0] dividend;
  logic [31:0] divisor;
  logic [63:0] result;
  logic        done;

  logic        last;
  logic        g_sat;
  logic [63:0] step_d;
  logic [63:0] pos_sum;
  logic [63:0] vel_sum;
  logic [63:0] ke_sum;
  logic [63:0] s1;
  logic [63:0] hi;
  logic [31:0] lo;
  logic        accept;

  assign mass   = (mass_q == 31'd0) ? 31'd1 : mass_q;
  assign last   = idx_q == 2'(DIMS - 1);
  assign g_sat  = h_q >= ({32'd0, r_q} << (31 - FRAC_BITS));
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s1     = acc_q >> FRAC_BITS;
  assign hi     = s1 >> (FRAC_BITS + 1);
  assign lo     = 32'(s1 & ((64'd1 << (FRAC_BITS + 1)) - 64'd1));

  assign step_d  = prod_q >> FRAC_BITS;
  assign pos_sum = {{32{pos_q[idx_q][31]}}, pos_q[idx_q]}
                 + (vel_q[idx_q][31] ? (~step_d + 64'd1) : step_d);
  assign vel_sum = {{32{vel_q[idx_q][31]}}, vel_q[idx_q]}
                 + (fneg_q[idx_q] ? (~result + 64'd1) : result);
  assign ke_sum  = tmp_q + (prod_q >> (FRAC_BITS + 1));

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= 16'd7;
      force_q <= 31'd65536;
      mass_q  <= 31'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfe_pkg::CFG_TIME_STEP: dt_q    <= cfg_data_i[15:0];
        cfe_pkg::CFG_FORCE:     force_q <= cfg_data_i;
        cfe_pkg::CFG_MASS:      mass_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cfe_pkg::ST_IDLE:
        if (accept && (s_axis_tuser == cfe_pkg::FUNC_STEP)) state_d = cfe_pkg::ST_SQ_MUL;
      cfe_pkg::ST_SQ_MUL:  state_d = cfe_pkg::ST_SQ_ACC;
      cfe_pkg::ST_SQ_ACC:  state_d = last ? cfe_pkg::ST_SQRT_GO : cfe_pkg::ST_SQ_MUL;
      cfe_pkg::ST_SQRT_GO: state_d = cfe_pkg::ST_SQRT_WAIT;
      cfe_pkg::ST_SQRT_WAIT:
        if (done) state_d = (result == 64'd0) ? cfe_pkg::ST_P_MUL : cfe_pkg::ST_H_GO;
      cfe_pkg::ST_H_GO:    state_d = cfe_pkg::ST_H_WAIT;
      cfe_pkg::ST_H_WAIT:  if (done) state_d = cfe_pkg::ST_G_CHK;
      cfe_pkg::ST_G_CHK:   state_d = g_sat ? cfe_pkg::ST_U_GO : cfe_pkg::ST_G_WAIT;
      cfe_pkg::ST_G_WAIT:  if (done) state_d = cfe_pkg::ST_U_GO;
      cfe_pkg::ST_U_GO:    state_d = cfe_pkg::ST_U_WAIT;
      cfe_pkg::ST_U_WAIT:  if (done) state_d = cfe_pkg::ST_F_MUL;
      cfe_pkg::ST_F_MUL:   state_d = cfe_pkg::ST_F_ACC;
      cfe_pkg::ST_F_ACC:   state_d = last ? cfe_pkg::ST_P_MUL : cfe_pkg::ST_U_GO;
      cfe_pkg::ST_P_MUL:   state_d = cfe_pkg::ST_P_ADD;
      cfe_pkg::ST_P_ADD:   state_d = last ? cfe_pkg::ST_V_MUL : cfe_pkg::ST_P_MUL;
      cfe_pkg::ST_V_MUL:   state_d = cfe_pkg::ST_V_GO;
      cfe_pkg::ST_V_GO:    state_d = cfe_pkg::ST_V_WAIT;
      cfe_pkg::ST_V_WAIT:
        if (done) state_d = last ? cfe_pkg::ST_K_MUL : cfe_pkg::ST_V_MUL;
      cfe_pkg::ST_K_MUL:   state_d = cfe_pkg::ST_K_ACC;
      cfe_pkg::ST_K_ACC:   state_d = last ? cfe_pkg::ST_K_HI : cfe_pkg::ST_K_MUL;
      cfe_pkg::ST_K_HI:    state_d = cfe_pkg::ST_K_LO;
      cfe_pkg::ST_K_LO:    state_d = cfe_pkg::ST_K_FIN;
      cfe_pkg::ST_K_FIN:   state_d = cfe_pkg::ST_OUT;
      cfe_pkg::ST_OUT:     if (m_axis_tready) state_d = cfe_pkg::ST_IDLE;
      default:             state_d = cfe_pkg::ST_IDLE;
    endcase
  end

  // shared multiplier operands and unit requests
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    req      = '{start: 1'b0, op: cfe_pkg::UOP_DIV};
    dividend = '0;
    divisor  = r_q;
    case (state_q)
      cfe_pkg::ST_SQ_MUL: begin
        mul_a = cfe_pkg::abs32(pos_q[idx_q]);
        mul_b = cfe_pkg::abs32(pos_q[idx_q]);
      end
      cfe_pkg::ST_SQRT_GO: begin
        req      = '{start: 1'b1, op: cfe_pkg::UOP_SQRT};
        dividend = acc_q;
      end
      cfe_pkg::ST_H_GO: begin
        req.start = 1'b1;
        dividend  = {33'd0, force_q} << FRAC_BITS;
      end
      cfe_pkg::ST_G_CHK: begin
        req.start = !g_sat;
        dividend  = h_q << FRAC_BITS;
      end
      cfe_pkg::ST_U_GO: begin
        req.start = 1'b1;
        dividend  = {32'd0, cfe_pkg::abs32(pos_q[idx_q])} << FRAC_BITS;
      end
      cfe_pkg::ST_F_MUL: begin
        mul_a = {1'b0, g_q};
        mul_b = u_q;
      end
      cfe_pkg::ST_P_MUL: begin
        mul_a = cfe_pkg::abs32(vel_q[idx_q]);
        mul_b = {16'd0, dt_q};
      end
      cfe_pkg::ST_V_MUL: begin
        mul_a = {1'b0, fmag_q[idx_q]};
        mul_b = {16'd0, dt_q};
      end
      cfe_pkg::ST_V_GO: begin
        req.start = 1'b1;
        dividend  = prod_q;
        divisor   = {1'b0, mass};
      end
      cfe_pkg::ST_K_MUL: begin
        mul_a = cfe_pkg::abs32(vel_q[idx_q]);
        mul_b = cfe_pkg::abs32(vel_q[idx_q]);
      end
      cfe_pkg::ST_K_HI: begin
        mul_a = {1'b0, mass};
        mul_b = hi[31:0];
      end
      cfe_pkg::ST_K_LO: begin
        mul_a = {1'b0, mass};
        mul_b = lo;
      end
      default: ;
    endcase
  end

  cfe_divsqrt u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .result_o   (result),
    .done_o     (done)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfe_pkg::ST_IDLE;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      time_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        cfe_pkg::ST_IDLE:
          if (accept && (s_axis_tuser == cfe_pkg::FUNC_LOAD)) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= (i < DIMS) ? s_axis_tdata[32*i +: 32] : 32'd0;
              vel_q[i] <= (i < DIMS) ? s_axis_tdata[96 + 32*i +: 32] : 32'd0;
            end
            time_q <= s_axis_tdata[223:192];
          end
        cfe_pkg::ST_P_ADD: pos_q[idx_q] <= cfe_pkg::sat32(pos_sum);
        cfe_pkg::ST_V_WAIT:
          if (done) begin
            vel_q[idx_q] <= cfe_pkg::sat32(vel_sum);
            if (last) time_q <= cfe_pkg::sat32({{32{time_q[31]}}, time_q} + {48'd0, dt_q});
          end
        default: ;
      endcase
    end
  end

  // datapath scratch registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      cfe_pkg::ST_IDLE: begin
        idx_q <= '0;
        acc_q <= '0;
      end
      cfe_pkg::ST_SQ_ACC: begin
        acc_q <= acc_q + prod_q;
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
      cfe_pkg::ST_SQRT_WAIT:
        if (done) begin
          r_q    <= result[31:0];
          sing_q <= result == 64'd0;
          pot_q  <= cfe_pkg::S32_MIN;
          for (int i = 0; i < 3; i++) begin
            fmag_q[i] <= '0;
            fneg_q[i] <= 1'b0;
          end
        end
      cfe_pkg::ST_H_WAIT:
        if (done) begin
          h_q   <= result;
          pot_q <= (result > 64'h8000_0000) ? cfe_pkg::S32_MIN : (~result[31:0] + 32'd1);
        end
      cfe_pkg::ST_G_CHK:   if (g_sat) g_q <= cfe_pkg::U31_MAX;
      cfe_pkg::ST_G_WAIT:  if (done) g_q <= result[30:0];
      cfe_pkg::ST_U_WAIT:  if (done) u_q <= result[31:0];
      cfe_pkg::ST_F_ACC: begin
        fmag_q[idx_q] <= 31'(prod_q >> FRAC_BITS);
        fneg_q[idx_q] <= ~pos_q[idx_q][31];
        idx_q         <= last ? 2'd0 : idx_q + 2'd1;
      end
      cfe_pkg::ST_P_ADD:   idx_q <= last ? 2'd0 : idx_q + 2'd1;
      cfe_pkg::ST_V_WAIT:
        if (done) begin
          idx_q <= last ? 2'd0 : idx_q + 2'd1;
          acc_q <= '0;
        end
      cfe_pkg::ST_K_ACC: begin
        acc_q <= acc_q + prod_q;
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
      cfe_pkg::ST_K_HI:    hisat_q <= hi[63:32] != 32'd0;
      cfe_pkg::ST_K_LO:    tmp_q <= prod_q;
      cfe_pkg::ST_K_FIN:
        ke_q <= (hisat_q || (ke_sum > {33'd0, cfe_pkg::U31_MAX})) ? cfe_pkg::U31_MAX
                                                                  : ke_sum[30:0];
      default: ;
    endcase
  end

  assign s_axis_tready = state_q == cfe_pkg::ST_IDLE;
  assign m_axis_tvalid = state_q == cfe_pkg::ST_OUT;
  assign m_axis_tdata  = {1'b0, sing_q, time_q, pot_q, ke_q,
                          (r_q[31] ? cfe_pkg::U31_MAX : r_q[30:0]),
                          pos_q[2], pos_q[1], pos_q[0]};

  ap_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready and result valid together");

  ap_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_axis_tuser == cfe_pkg::FUNC_STEP)) |=> !s_axis_tready)
    else $error("step word did not hold off input");

  ap_singular: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[222]) |->
      (m_axis_tdata[126:96] == 31'd0) && (m_axis_tdata[189:158] == cfe_pkg::S32_MIN))
    else $error("singular result without zero distance and saturated potential");

endmodule
